// ===== rtl/core/mvsm_pkg.sv =====
`timescale 1ns / 1ps

package mvsm_pkg;

    localparam int VOICE_COUNT = 32;
    localparam int SOUND_COUNT = 64;
    localparam int PCM_WORDS   = 65536;

    localparam int VW = $clog2(VOICE_COUNT);
    localparam int SW = $clog2(SOUND_COUNT);
    localparam int AW = $clog2(PCM_WORDS);

    localparam logic [3:0] OP_TICK   = 4'd0;
    localparam logic [3:0] OP_WRITE  = 4'd1;
    localparam logic [3:0] OP_DEFINE = 4'd2;
    localparam logic [3:0] OP_UNLOAD = 4'd3;
    localparam logic [3:0] OP_PLAY   = 4'd4;
    localparam logic [3:0] OP_STOP   = 4'd5;
    localparam logic [3:0] OP_VOLUME = 4'd6;
    localparam logic [3:0] OP_SSTART = 4'd7;
    localparam logic [3:0] OP_SSTOP  = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADID = 2'd2;

    localparam logic [15:0] UNITY_GAIN  = 16'h8000;
    localparam logic [16:0] MAX_LEN     = 17'h10000;
    localparam logic [10:0] HANDLE_BASE = 11'd1000;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic [3:0]  op;
        logic        is_song;
        logic        is_voice;
        logic        is_sound;
        logic [VW-1:0] voice_idx;
        logic [SW-1:0] sound_idx;
        logic [10:0] id;
        logic [15:0] address;
        logic [15:0] word;
        logic [16:0] len;
        logic        loop_flag;
        logic [15:0] vol;
    } cmd_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'sh7fff;
        if (v < -18'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== rtl/core/mvsm_ram.sv =====
`timescale 1ns / 1ps

module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mvsm_front.sv =====
`timescale 1ns / 1ps

module mvsm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        operation,
    input  logic [15:0]       address,
    input  logic [15:0]       pcm_word,
    input  logic [16:0]       length_words,
    input  logic [10:0]       id_value,
    input  logic              loop_flag,
    input  logic [15:0]       volume,
    output logic              q_valid,
    input  logic              q_ready,
    output mvsm_pkg::cmd_t    q_cmd
);

    localparam int QD = 2;

    mvsm_pkg::cmd_t q_reg [QD];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    mvsm_pkg::cmd_t cmd;
    logic [10:0]    vrel;
    logic [10:0]    srel;

    // Classify the id and clamp length and volume.
    always_comb begin
        vrel          = id_value - mvsm_pkg::HANDLE_BASE - 11'd1;
        srel          = id_value - 11'd1;
        cmd.op        = operation;
        cmd.id        = id_value;
        cmd.is_song   = (id_value == 11'd0);
        cmd.is_voice  = (id_value > mvsm_pkg::HANDLE_BASE) &&
                        (id_value <= mvsm_pkg::HANDLE_BASE + 11'(mvsm_pkg::VOICE_COUNT));
        cmd.is_sound  = (id_value >= 11'd1) &&
                        (id_value <= 11'(mvsm_pkg::SOUND_COUNT));
        cmd.voice_idx = vrel[mvsm_pkg::VW-1:0];
        cmd.sound_idx = srel[mvsm_pkg::SW-1:0];
        cmd.address   = address;
        cmd.word      = pcm_word;
        cmd.len       = (length_words > mvsm_pkg::MAX_LEN) ? mvsm_pkg::MAX_LEN
                                                           : length_words;
        cmd.loop_flag = loop_flag;
        cmd.vol       = (volume > mvsm_pkg::UNITY_GAIN) ? mvsm_pkg::UNITY_GAIN : volume;
    end

    assign in_ready = (cnt_reg != 2'(QD));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rp_reg];

    // Two-entry queue pointers.
    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (in_valid && in_ready) begin
            wp_next  = ~wp_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (q_valid && q_ready) begin
            rp_next  = ~rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (in_valid && in_ready) begin
            q_reg[wp_reg] <= cmd;
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QD)) else $error("queue overflow");
    a_no_under: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("queue underflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(QD)) |-> !in_ready) else $error("accept while full");

endmodule

// ===== rtl/core/mvsm_back.sv =====
`timescale 1ns / 1ps

module mvsm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  mvsm_pkg::cmd_t      q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_left_sample,
    output logic signed [15:0]  m_right_sample,
    output logic [10:0]         m_handle,
    output logic [1:0]          m_status
);

    localparam int VW = mvsm_pkg::VW;
    localparam int SW = mvsm_pkg::SW;
    localparam int AW = mvsm_pkg::AW;
    localparam int NV = mvsm_pkg::VOICE_COUNT;
    localparam int NS = mvsm_pkg::SOUND_COUNT;
    localparam int SRCW = $clog2(NV + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRC  = 3'd1;
    localparam logic [2:0] S_RDL  = 3'd2;
    localparam logic [2:0] S_RDR  = 3'd3;
    localparam logic [2:0] S_MIXL = 3'd4;
    localparam logic [2:0] S_MIXR = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_PLAY = 3'd7;

    logic [2:0] state_reg;

    // Sound load flags and voice tables.
    logic [NS-1:0] s_loaded_reg;
    logic [NV-1:0] v_play_reg, v_loop_reg;
    logic [15:0]   v_gain_reg  [NV];
    logic [16:0]   v_pos_reg   [NV];
    logic [15:0]   v_start_reg [NV];
    logic [16:0]   v_len_reg   [NV];
    logic [10:0]   v_sound_reg [NV];
    logic          g_play_reg;
    logic [15:0]   g_gain_reg, g_start_reg;
    logic [16:0]   g_pos_reg, g_len_reg;

    mvsm_pkg::cmd_t cmd_reg;
    logic [SRCW-1:0] src_reg;
    logic signed [15:0] l_reg, r_reg;
    logic signed [31:0] prod_reg;
    logic [15:0] gsel_reg, base_reg;
    logic [16:0] psel_reg;

    logic signed [15:0] o_l_reg, o_r_reg;
    logic [10:0] o_h_reg;
    logic [1:0]  o_s_reg;
    logic        o_v_reg;

    logic        ram_we;
    logic [AW-1:0] ram_raddr;
    logic [15:0] ram_rdata;

    mvsm_ram #(.WIDTH(16), .DEPTH(mvsm_pkg::PCM_WORDS)) u_pcm (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_cmd.address[AW-1:0]),
        .wdata (q_cmd.word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_ready = (state_reg == S_IDLE) && !o_v_reg;
    assign ram_we  = q_valid && q_ready && (q_cmd.op == mvsm_pkg::OP_WRITE);
    assign m_valid = o_v_reg;
    assign m_left_sample  = o_l_reg;
    assign m_right_sample = o_r_reg;
    assign m_handle = o_h_reg;
    assign m_status = o_s_reg;

    // Current source view: index 0 is the song, then voice src-1.
    logic          c_play, c_loop;
    logic [15:0]   c_gain, c_start;
    logic [16:0]   c_pos, c_len;
    logic [VW-1:0] vi;
    always_comb begin
        vi = VW'(src_reg - SRCW'(1));
        if (src_reg == '0) begin
            c_play = g_play_reg; c_loop = 1'b1; c_gain = g_gain_reg;
            c_start = g_start_reg; c_pos = g_pos_reg; c_len = g_len_reg;
        end else begin
            c_play = v_play_reg[vi]; c_loop = v_loop_reg[vi]; c_gain = v_gain_reg[vi];
            c_start = v_start_reg[vi]; c_pos = v_pos_reg[vi]; c_len = v_len_reg[vi];
        end
    end

    // Word address for the current read.
    logic [15:0] rd_off;
    always_comb begin
        rd_off = psel_reg[15:0] + ((state_reg == S_RDR) ? 16'd1 : 16'd0);
        ram_raddr = AW'(base_reg + rd_off);
    end

    // First free slots.
    logic [SW-1:0] free_s; logic free_s_ok;
    logic [VW-1:0] free_v; logic free_v_ok;
    always_comb begin
        free_s = '0; free_s_ok = 1'b0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!s_loaded_reg[i]) begin free_s = SW'(i); free_s_ok = 1'b1; end
        end
        free_v = '0; free_v_ok = 1'b0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (!v_play_reg[i]) begin free_v = VW'(i); free_v_ok = 1'b1; end
        end
    end

    // Sound tables: start and length are written on define, the gain on define,
    // unload and volume. A play reads all three at the slot of the queue head.
    logic          s_tab_we;
    logic          s_gain_we;
    logic [SW-1:0] s_gain_waddr;
    logic [15:0]   s_gain_wdata;
    logic [15:0]   s_start_rd, s_gain_rd;
    logic [16:0]   s_len_rd;

    assign s_tab_we = q_valid && q_ready && (q_cmd.op == mvsm_pkg::OP_DEFINE) && free_s_ok;

    always_comb begin
        s_gain_we    = 1'b0;
        s_gain_waddr = q_cmd.sound_idx;
        s_gain_wdata = q_cmd.vol;
        if (q_valid && q_ready) begin
            case (q_cmd.op)
                mvsm_pkg::OP_DEFINE: begin
                    s_gain_we    = free_s_ok;
                    s_gain_waddr = free_s;
                    s_gain_wdata = mvsm_pkg::UNITY_GAIN;
                end
                mvsm_pkg::OP_UNLOAD: begin
                    s_gain_we    = q_cmd.is_sound;
                    s_gain_wdata = mvsm_pkg::UNITY_GAIN;
                end
                mvsm_pkg::OP_VOLUME: s_gain_we = q_cmd.is_sound;
                default: s_gain_we = 1'b0;
            endcase
        end
    end

    mvsm_ram #(.WIDTH(16), .DEPTH(NS)) u_s_start (
        .aclk  (aclk),
        .we    (s_tab_we),
        .waddr (free_s),
        .wdata (q_cmd.address),
        .raddr (q_cmd.sound_idx),
        .rdata (s_start_rd)
    );

    mvsm_ram #(.WIDTH(17), .DEPTH(NS)) u_s_len (
        .aclk  (aclk),
        .we    (s_tab_we),
        .waddr (free_s),
        .wdata (q_cmd.len),
        .raddr (q_cmd.sound_idx),
        .rdata (s_len_rd)
    );

    mvsm_ram #(.WIDTH(16), .DEPTH(NS)) u_s_gain (
        .aclk  (aclk),
        .we    (s_gain_we),
        .waddr (s_gain_waddr),
        .wdata (s_gain_wdata),
        .raddr (q_cmd.sound_idx),
        .rdata (s_gain_rd)
    );

    logic signed [31:0] prod_adj;
    logic signed [17:0] sum;
    always_comb begin
        prod_adj = prod_reg + ((prod_reg < 0) ? 32'sd32767 : 32'sd0);
        sum = 18'(((state_reg == S_MIXL) ? l_reg : r_reg)) + 18'(prod_adj >>> 15);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            o_v_reg      <= 1'b0;
            s_loaded_reg <= '0;
            v_play_reg   <= '0;
            v_loop_reg   <= '0;
            g_play_reg   <= 1'b0;
            g_gain_reg   <= mvsm_pkg::UNITY_GAIN;
            g_pos_reg    <= '0;
            g_start_reg  <= '0;
            g_len_reg    <= '0;
            for (int i = 0; i < NV; i++) begin
                v_gain_reg[i]  <= mvsm_pkg::UNITY_GAIN;
                v_pos_reg[i]   <= '0;
                v_start_reg[i] <= '0;
                v_len_reg[i]   <= '0;
                v_sound_reg[i] <= '0;
            end
        end else begin
            if (o_v_reg && m_ready) o_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cmd_reg <= q_cmd;
                        o_l_reg <= '0; o_r_reg <= '0;
                        o_h_reg <= '0; o_s_reg <= mvsm_pkg::ST_OK;
                        case (q_cmd.op)
                            mvsm_pkg::OP_TICK: begin
                                src_reg <= '0; l_reg <= '0; r_reg <= '0;
                                state_reg <= S_SRC;
                            end
                            mvsm_pkg::OP_WRITE: o_v_reg <= 1'b1;
                            mvsm_pkg::OP_DEFINE: begin
                                o_v_reg <= 1'b1;
                                if (free_s_ok) begin
                                    s_loaded_reg[free_s] <= 1'b1;
                                    o_h_reg <= 11'(free_s) + 11'd1;
                                end else o_s_reg <= mvsm_pkg::ST_FULL;
                            end
                            mvsm_pkg::OP_UNLOAD: begin
                                o_v_reg <= 1'b1;
                                if (q_cmd.is_sound) begin
                                    s_loaded_reg[q_cmd.sound_idx] <= 1'b0;
                                end else o_s_reg <= mvsm_pkg::ST_BADID;
                            end
                            // The sound tables answer in the cycle after the accept.
                            mvsm_pkg::OP_PLAY: state_reg <= S_PLAY;
                            mvsm_pkg::OP_STOP: begin
                                o_v_reg <= 1'b1;
                                if (q_cmd.is_song) g_play_reg <= 1'b0;
                                else if (q_cmd.is_voice) v_play_reg[q_cmd.voice_idx] <= 1'b0;
                                else if (q_cmd.is_sound) begin
                                    for (int i = 0; i < NV; i++)
                                        if (v_sound_reg[i] == q_cmd.id) v_play_reg[i] <= 1'b0;
                                end else o_s_reg <= mvsm_pkg::ST_BADID;
                            end
                            mvsm_pkg::OP_VOLUME: begin
                                o_v_reg <= 1'b1;
                                if (q_cmd.is_song) g_gain_reg <= q_cmd.vol;
                                else if (q_cmd.is_voice) v_gain_reg[q_cmd.voice_idx] <= q_cmd.vol;
                                else if (q_cmd.is_sound) begin
                                    for (int i = 0; i < NV; i++)
                                        if (v_sound_reg[i] == q_cmd.id) v_gain_reg[i] <= q_cmd.vol;
                                end else o_s_reg <= mvsm_pkg::ST_BADID;
                            end
                            mvsm_pkg::OP_SSTART: begin
                                o_v_reg <= 1'b1;
                                g_play_reg <= 1'b1; g_gain_reg <= mvsm_pkg::UNITY_GAIN;
                                g_pos_reg <= '0; g_start_reg <= q_cmd.address;
                                g_len_reg <= q_cmd.len;
                            end
                            mvsm_pkg::OP_SSTOP: begin
                                o_v_reg <= 1'b1; g_play_reg <= 1'b0;
                            end
                            default: begin
                                o_v_reg <= 1'b1; o_s_reg <= mvsm_pkg::ST_BADID;
                            end
                        endcase
                    end
                end
                // Start a voice from the sound table entry read at accept.
                S_PLAY: begin
                    o_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                    if (!cmd_reg.is_sound || !s_loaded_reg[cmd_reg.sound_idx] ||
                        s_len_rd == 17'd0) begin
                        o_s_reg <= mvsm_pkg::ST_BADID;
                    end else if (!free_v_ok) begin
                        o_s_reg <= mvsm_pkg::ST_FULL;
                    end else begin
                        v_play_reg[free_v]  <= 1'b1;
                        v_loop_reg[free_v]  <= cmd_reg.loop_flag;
                        v_gain_reg[free_v]  <= s_gain_rd;
                        v_pos_reg[free_v]   <= '0;
                        v_start_reg[free_v] <= s_start_rd;
                        v_len_reg[free_v]   <= s_len_rd;
                        v_sound_reg[free_v] <= cmd_reg.id;
                        o_h_reg <= mvsm_pkg::HANDLE_BASE + 11'(free_v) + 11'd1;
                    end
                end
                // Decide what the current source does this frame.
                S_SRC: begin
                    gsel_reg <= c_gain; base_reg <= c_start;
                    if (!c_play || c_len < 17'd2) begin
                        state_reg <= S_OUT;
                    end else if (c_pos + 17'd1 >= c_len && !c_loop) begin
                        v_play_reg[vi] <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        psel_reg <= (c_pos + 17'd1 >= c_len) ? 17'd0 : c_pos;
                        state_reg <= S_RDL;
                    end
                end
                S_RDL: state_reg <= S_RDR;
                S_RDR: begin
                    prod_reg <= $signed(ram_rdata) * $signed({1'b0, gsel_reg});
                    state_reg <= S_MIXL;
                end
                S_MIXL: begin
                    l_reg <= mvsm_pkg::sat16(sum);
                    prod_reg <= $signed(ram_rdata) * $signed({1'b0, gsel_reg});
                    state_reg <= S_MIXR;
                end
                S_MIXR: begin
                    r_reg <= mvsm_pkg::sat16(sum);
                    if (src_reg == '0) g_pos_reg <= psel_reg + 17'd2;
                    else v_pos_reg[vi] <= psel_reg + 17'd2;
                    state_reg <= S_OUT;
                end
                // Advance to the next source or deliver the frame.
                S_OUT: begin
                    if (src_reg == SRCW'(NV)) begin
                        o_l_reg <= l_reg; o_r_reg <= r_reg; o_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        src_reg <= src_reg + SRCW'(1);
                        state_reg <= S_SRC;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (o_v_reg && !m_ready) |=> (o_v_reg && $stable(o_l_reg))) else $error("result lost");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !q_ready) else $error("accept while busy");
    a_tick_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && src_reg == SRCW'(NV)) |=> o_v_reg) else $error("frame lost");

endmodule

// ===== rtl/core/multi_voice_sample_mixer_top.sv =====
`timescale 1ns / 1ps

// Stereo PCM playback mixer with one song and 32 voices. Every transfer gives
// one result. Play reads the sound tables before it gives its result. A tick
// walks the song and then each voice in turn through one sample memory read
// port: an idle source passes S_SRC and S_OUT, a playing one S_SRC, S_RDL,
// S_RDR, S_MIXL, S_MIXR and S_OUT. A two-entry queue sits between the input
// and the execution engine so that the input side keeps taking transfers,
// until the queue is full, while the engine works or a result waits; the
// engine takes its next command only after its result has been transferred.
module multi_voice_sample_mixer_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_operation,
    input  logic [15:0]        s_address,
    input  logic signed [15:0] s_pcm_word,
    input  logic [16:0]        s_length_words,
    input  logic [10:0]        s_id_value,
    input  logic               s_loop_flag,
    input  logic [15:0]        s_volume,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_sample,
    output logic signed [15:0] m_right_sample,
    output logic [10:0]        m_handle,
    output logic [1:0]         m_status
);

    logic           q_valid, q_ready;
    mvsm_pkg::cmd_t q_cmd;

    mvsm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .operation(s_operation), .address(s_address), .pcm_word(s_pcm_word),
        .length_words(s_length_words), .id_value(s_id_value),
        .loop_flag(s_loop_flag), .volume(s_volume),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    mvsm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_valid(m_valid), .m_ready(m_ready),
        .m_left_sample(m_left_sample), .m_right_sample(m_right_sample),
        .m_handle(m_handle), .m_status(m_status)
    );

endmodule
